// ----- rtl/hpm_pkg.sv -----
// Shared types, template window table and helpers for the half-strip
// pattern matcher. No dependencies.
package hpm_pkg;

  localparam int HS_WIDTH      = 11;
  localparam int NUM_LAYERS    = 6;
  localparam int NUM_TEMPLATES = 9;
  localparam int COUNT_W       = 3;
  localparam int ID_W          = 4;
  localparam int KEY_W         = COUNT_W + ID_W;

  // Pattern ids run from FIRST_ID to LAST_ID, one per template.
  localparam int FIRST_ID = 'h2;
  localparam int LAST_ID  = 'hA;

  typedef logic [HS_WIDTH-1:0] hits_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [ID_W-1:0]     id_t;
  typedef logic [KEY_W-1:0]    key_t;

  // Window masks, indexed by [template][layer]; template 0 is id FIRST_ID.
  localparam hits_t WINDOWS [NUM_TEMPLATES][NUM_LAYERS] = '{
    '{11'h700, 11'h0C0, 11'h020, 11'h038, 11'h00E, 11'h007},
    '{11'h007, 11'h018, 11'h020, 11'h0E0, 11'h380, 11'h700},
    '{11'h380, 11'h0C0, 11'h020, 11'h018, 11'h00E, 11'h00E},
    '{11'h00E, 11'h018, 11'h020, 11'h0C0, 11'h380, 11'h380},
    '{11'h1C0, 11'h060, 11'h020, 11'h030, 11'h018, 11'h01C},
    '{11'h01C, 11'h030, 11'h020, 11'h060, 11'h0C0, 11'h1C0},
    '{11'h0E0, 11'h060, 11'h020, 11'h030, 11'h038, 11'h038},
    '{11'h038, 11'h030, 11'h020, 11'h060, 11'h0E0, 11'h0E0},
    '{11'h070, 11'h020, 11'h020, 11'h020, 11'h070, 11'h070}
  };

  // The ranking key is {count, id}; ids are distinct, so the larger key
  // is the higher count, and on equal counts the higher id.
  function automatic key_t max_key(input key_t a, input key_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ----- rtl/hpm_score.sv -----
// Per-template layer scoring for the half-strip pattern matcher.
// Depends on hpm_pkg for the window table and types.
module hpm_score (
  input  hpm_pkg::hits_t  hits_i   [hpm_pkg::NUM_LAYERS],
  output hpm_pkg::count_t scores_o [hpm_pkg::NUM_TEMPLATES]
);

  // A layer counts toward a template when any hit falls inside its window.
  always_comb begin
    hpm_pkg::count_t cnt;
    for (int t = 0; t < hpm_pkg::NUM_TEMPLATES; t++) begin
      cnt = '0;
      for (int ly = 0; ly < hpm_pkg::NUM_LAYERS; ly++) begin
        cnt = cnt + hpm_pkg::COUNT_W'(|(hits_i[ly] & hpm_pkg::WINDOWS[t][ly]));
      end
      scores_o[t] = cnt;
    end
  end

endmodule

// ----- rtl/halfstrip_pattern_matcher.sv -----
// Half-strip bend-pattern matcher: input register, scoring, result register.
// Throughput: one transaction per cycle; busy is never raised, since the
// receiver cannot stall and every stage advances each cycle.
// Reset: asynchronous, active low; clears the two stage valid flags only.
// Depends on hpm_pkg and hpm_score.
module halfstrip_pattern_matcher (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  hpm_pkg::hits_t       layer0_hits_i,
  input  hpm_pkg::hits_t       layer1_hits_i,
  input  hpm_pkg::hits_t       layer2_hits_i,
  input  hpm_pkg::hits_t       layer3_hits_i,
  input  hpm_pkg::hits_t       layer4_hits_i,
  input  hpm_pkg::hits_t       layer5_hits_i,
  output logic                 done_o,
  output hpm_pkg::count_t      best_layer_count_o,
  output hpm_pkg::id_t         best_pattern_id_o
);

  // The pipeline never stalls, so a new transaction is always welcome.
  assign busy = 1'b0;

  // Stage 1: capture the hit bits of an accepted transaction.
  logic           in_valid_q;
  hpm_pkg::hits_t hits_q [hpm_pkg::NUM_LAYERS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      hits_q[0] <= layer0_hits_i;
      hits_q[1] <= layer1_hits_i;
      hits_q[2] <= layer2_hits_i;
      hits_q[3] <= layer3_hits_i;
      hits_q[4] <= layer4_hits_i;
      hits_q[5] <= layer5_hits_i;
    end
  end

  // Score every template in parallel from the registered hits.
  hpm_pkg::count_t scores [hpm_pkg::NUM_TEMPLATES];

  hpm_score u_score (
    .hits_i   (hits_q),
    .scores_o (scores)
  );

  // Pick the best template with a four-level max tree over {count, id}
  // keys. Because the id is the low part of the key, equal counts resolve
  // toward the higher id, which also gives the last id when nothing hits.
  hpm_pkg::key_t keys [hpm_pkg::NUM_TEMPLATES];
  hpm_pkg::key_t lvl1 [4];
  hpm_pkg::key_t lvl2 [2];
  hpm_pkg::key_t lvl3;
  hpm_pkg::key_t best_key;

  always_comb begin
    for (int t = 0; t < hpm_pkg::NUM_TEMPLATES; t++) begin
      keys[t] = {scores[t], hpm_pkg::ID_W'(hpm_pkg::FIRST_ID + t)};
    end
    for (int i = 0; i < 4; i++) begin
      lvl1[i] = hpm_pkg::max_key(keys[2*i], keys[2*i+1]);
    end
    lvl2[0]  = hpm_pkg::max_key(lvl1[0], lvl1[1]);
    lvl2[1]  = hpm_pkg::max_key(lvl1[2], lvl1[3]);
    lvl3     = hpm_pkg::max_key(lvl2[0], lvl2[1]);
    best_key = hpm_pkg::max_key(lvl3, keys[hpm_pkg::NUM_TEMPLATES-1]);
  end

  // Stage 2: result register; the strobe marks one cycle per transaction.
  logic            done_q;
  hpm_pkg::count_t count_q;
  hpm_pkg::id_t    id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      count_q <= best_key[hpm_pkg::KEY_W-1:hpm_pkg::ID_W];
      id_q    <= best_key[hpm_pkg::ID_W-1:0];
    end
  end

  assign done_o             = done_q;
  assign best_layer_count_o = count_q;
  assign best_pattern_id_o  = id_q;

endmodule
